// File: rtl/dbid_pkg.sv
package dbid_pkg;

    // Block geometry and symbol width.
    localparam int BLOCK_LEN = 126;
    localparam int MAX_BITS  = 6;
    localparam int POS_W     = 7;

    // Each plane memory holds two banks addressed as {bank, position}.
    localparam int RAM_AW    = POS_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    typedef logic [POS_W-1:0]    pos_t;
    typedef logic [RAM_AW-1:0]   ram_addr_t;
    typedef logic [1:0]          mode_t;
    typedef logic [MAX_BITS-1:0] sym_t;

    localparam mode_t MODE_QPSK  = 2'd0;
    localparam mode_t MODE_16QAM = 2'd1;
    localparam mode_t MODE_64QAM = 2'd2;

    // Word index of the constellation mode register.
    localparam logic CFG_IDX_MODE = 1'b0;

    localparam pos_t LAST_POS = pos_t'(BLOCK_LEN - 1);

    // Position offset of each bit plane within the block.
    localparam pos_t PLANE_OFFSET [MAX_BITS] = '{
        7'd0, 7'd63, 7'd105, 7'd42, 7'd21, 7'd84
    };

endpackage

// File: rtl/dbid_plane_ram.sv
module dbid_plane_ram (
    input  logic                    clk,
    input  logic                    wr_en,
    input  dbid_pkg::ram_addr_t     wr_addr,
    input  logic                    wr_data,
    input  logic                    rd_en,
    input  dbid_pkg::ram_addr_t     rd_addr,
    output logic                    rd_data
);

    logic mem [dbid_pkg::RAM_DEPTH];
    logic rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/dvbt_bit_inner_deinterleaver_unit.sv
// A request's read data is registered in the read stage, then in the output register.
// Throughput: one request per cycle unless in_stall; each reads all planes, writes used ones.
// The first 126 requests after reset fill a block and produce no result; after that
// each request produces one symbol of the previously filled block.
// Reset clears position, bank, block-ready flag, mode and pipeline valids; the plane
// memories are not cleared.
module dvbt_bit_inner_deinterleaver_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [5:0]           in_symbol,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [5:0]           out_symbol,
    output logic                 end_of_block,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int NB = dbid_pkg::MAX_BITS;

    dbid_pkg::mode_t mode_reg;
    dbid_pkg::pos_t  position_reg;
    dbid_pkg::pos_t  position_next;
    logic            write_bank_reg;
    logic            write_bank_next;
    logic            previous_ready_reg;
    logic            previous_ready_next;

    logic            s1_valid_reg;
    logic            s1_last_reg;
    dbid_pkg::mode_t s1_mode_reg;

    logic            out_valid_reg;
    dbid_pkg::sym_t  out_symbol_reg;
    dbid_pkg::sym_t  out_symbol_next;
    logic            end_of_block_reg;

    logic            out_ok;
    logic            s1_ok;
    logic            accept;

    dbid_pkg::sym_t  plane_wdata;
    dbid_pkg::sym_t  plane_wmask;
    dbid_pkg::sym_t  plane_rdata;

    // Configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= dbid_pkg::MODE_QPSK;
        end
        else if (psel && penable && pwrite && (paddr[2] == dbid_pkg::CFG_IDX_MODE))
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == dbid_pkg::CFG_IDX_MODE) ? {30'd0, mode_reg} : 32'd0;

    // Handshake: the read stage moves whenever the output register can take its result.
    assign out_ok   = !out_valid_reg || !out_stall;
    assign s1_ok    = !s1_valid_reg || out_ok;
    assign in_stall = !s1_ok;
    assign accept   = in_valid && s1_ok;

    // Block position and bank control
    always_comb
    begin
        position_next       = position_reg;
        write_bank_next     = write_bank_reg;
        previous_ready_next = previous_ready_reg;
        if (accept)
        begin
            if (position_reg == dbid_pkg::LAST_POS)
            begin
                position_next       = '0;
                write_bank_next     = !write_bank_reg;
                previous_ready_next = 1'b1;
            end
            else
            begin
                position_next = position_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg       <= '0;
            write_bank_reg     <= 1'b0;
            previous_ready_reg <= 1'b0;
        end
        else
        begin
            position_reg       <= position_next;
            write_bank_reg     <= write_bank_next;
            previous_ready_reg <= previous_ready_next;
        end
    end

    // Plane e takes symbol bit v-1-e; planes at or above v are left untouched.
    always_comb
    begin
        case (mode_reg)
            dbid_pkg::MODE_QPSK:
            begin
                plane_wdata = {4'd0, in_symbol[0], in_symbol[1]};
                plane_wmask = 6'b000011;
            end
            dbid_pkg::MODE_16QAM:
            begin
                plane_wdata = {2'd0, in_symbol[0], in_symbol[1], in_symbol[2], in_symbol[3]};
                plane_wmask = 6'b001111;
            end
            default:
            begin
                plane_wdata = {in_symbol[0], in_symbol[1], in_symbol[2],
                               in_symbol[3], in_symbol[4], in_symbol[5]};
                plane_wmask = 6'b111111;
            end
        endcase
    end

    for (genvar e = 0; e < NB; e++)
    begin : g_plane
        logic [dbid_pkg::POS_W:0] sum;
        dbid_pkg::pos_t           wr_pos;

        assign sum    = {1'b0, position_reg} + {1'b0, dbid_pkg::PLANE_OFFSET[e]};
        assign wr_pos = (sum >= (dbid_pkg::POS_W + 1)'(dbid_pkg::BLOCK_LEN))
                      ? dbid_pkg::pos_t'(sum - (dbid_pkg::POS_W + 1)'(dbid_pkg::BLOCK_LEN))
                      : sum[dbid_pkg::POS_W-1:0];

        dbid_plane_ram u_ram (
            .clk     (clk),
            .wr_en   (accept && plane_wmask[e]),
            .wr_addr ({write_bank_reg, wr_pos}),
            .wr_data (plane_wdata[e]),
            .rd_en   (accept),
            .rd_addr ({!write_bank_reg, position_reg}),
            .rd_data (plane_rdata[e])
        );
    end

    // Read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ok)
        begin
            s1_valid_reg <= accept && previous_ready_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg <= (position_reg == dbid_pkg::LAST_POS);
            s1_mode_reg <= mode_reg;
        end
    end

    // Output bit k comes from plane k/(v/2) + 2*(k mod (v/2)), MSB first.
    always_comb
    begin
        case (s1_mode_reg)
            dbid_pkg::MODE_QPSK:
            begin
                out_symbol_next = {4'd0, plane_rdata[0], plane_rdata[1]};
            end
            dbid_pkg::MODE_16QAM:
            begin
                out_symbol_next = {2'd0, plane_rdata[0], plane_rdata[2],
                                   plane_rdata[1], plane_rdata[3]};
            end
            default:
            begin
                out_symbol_next = {plane_rdata[0], plane_rdata[2], plane_rdata[4],
                                   plane_rdata[1], plane_rdata[3], plane_rdata[5]};
            end
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ok)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ok && s1_valid_reg)
        begin
            out_symbol_reg   <= out_symbol_next;
            end_of_block_reg <= s1_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_symbol   = out_symbol_reg;
    assign end_of_block = end_of_block_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= dbid_pkg::LAST_POS)
        else $error("block position out of range");

    a_out_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> previous_ready_reg)
        else $error("result before first block filled");

    a_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && previous_ready_reg) |=> s1_valid_reg)
        else $error("accepted request lost in read stage");

    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && position_reg == dbid_pkg::LAST_POS)
        |=> (position_reg == '0 && previous_ready_reg
             && write_bank_reg != $past(write_bank_reg)))
        else $error("bank swap at block end failed");
`endif

endmodule

// File: tb/dvbt_bit_inner_deinterleaver_unit_tb.sv
module dvbt_bit_inner_deinterleaver_unit_tb;

    localparam int SPAN        = 126;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 4;
    localparam int MAX_SHOWN   = 30;
    localparam int IDLE_PCT    = 21;
    localparam int PHASES      = 8;

    // The two-bit mode field has one spare code; the block treats it as 64QAM.
    localparam dbid_pkg::mode_t MODE_SPARE = 2'd3;
    localparam logic [2:0] MODE_ADDR = {dbid_pkg::CFG_IDX_MODE, 2'b00};

    localparam int PLANE_SHIFT [6] = '{0, 63, 105, 42, 21, 84};

    localparam dbid_pkg::sym_t CORNER_SYMBOLS [16] = '{
        6'd0, 6'd63, 6'd1, 6'd2, 6'd4, 6'd8, 6'd16, 6'd32,
        6'd62, 6'd61, 6'd59, 6'd55, 6'd47, 6'd31, 6'd42, 6'd21
    };

    localparam dbid_pkg::mode_t MODE_PLAN [PHASES] = '{
        dbid_pkg::MODE_16QAM, dbid_pkg::MODE_QPSK, MODE_SPARE, dbid_pkg::MODE_64QAM,
        dbid_pkg::MODE_QPSK, MODE_SPARE, dbid_pkg::MODE_16QAM, dbid_pkg::MODE_64QAM
    };

    logic           clk = 1'b0;
    logic           rst_n;
    logic           in_valid;
    logic           in_stall;
    dbid_pkg::sym_t in_symbol;
    logic           out_valid;
    logic           out_stall;
    logic [5:0]     out_symbol;
    logic           end_of_block;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    int idle_pct     = IDLE_PCT;
    bit hold_trigger = 1'b0;
    int cycle_count  = 0;

    class deint_scoreboard;
        dbid_pkg::sym_t  bank_store [2][SPAN];
        int              fill_pos;
        bit              fill_bank;
        bit              block_ready;
        dbid_pkg::mode_t mode;
        dbid_pkg::sym_t  want_symbol [$];
        bit              want_last [$];
        int              mismatches;
        int              symbols_in;
        int              symbols_out;

        function new();
            fill_pos    = 0;
            fill_bank   = 1'b0;
            block_ready = 1'b0;
            mode        = dbid_pkg::MODE_QPSK;
            mismatches  = 0;
            symbols_in  = 0;
            symbols_out = 0;
            foreach (bank_store[b, p])
                bank_store[b][p] = '0;
        endfunction

        function int bits_in(dbid_pkg::mode_t m);
            if (m == dbid_pkg::MODE_QPSK)
                return 2;
            if (m == dbid_pkg::MODE_16QAM)
                return 4;
            return 6;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("tb: mismatch: %s", what);
        endtask

        // Reads out the previous block at the current position, then scatters the
        // new symbol's bits over the filling bank.
        function void note_request(dbid_pkg::sym_t sym);
            int             nbits;
            int             half;
            int             plane;
            int             dest;
            dbid_pkg::sym_t entry;
            dbid_pkg::sym_t built;
            nbits = bits_in(mode);
            half  = nbits / 2;
            symbols_in++;
            if (block_ready)
            begin
                entry = bank_store[fill_bank ^ 1'b1][fill_pos];
                built = '0;
                for (int k = 0; k < nbits; k++)
                begin
                    plane = k / half + 2 * (k % half);
                    built = (built << 1) | dbid_pkg::sym_t'(entry[plane]);
                end
                want_symbol.push_back(built);
                want_last.push_back(fill_pos == SPAN - 1);
            end
            for (int e = 0; e < nbits; e++)
            begin
                dest = (fill_pos + PLANE_SHIFT[e]) % SPAN;
                bank_store[fill_bank][dest][e] = sym[nbits - 1 - e];
            end
            fill_pos++;
            if (fill_pos == SPAN)
            begin
                fill_pos    = 0;
                fill_bank   = ~fill_bank;
                block_ready = 1'b1;
            end
        endfunction

        task check_result(logic [5:0] got_symbol, logic got_last);
            dbid_pkg::sym_t sym;
            bit             last;
            symbols_out++;
            if (want_symbol.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", got_symbol));
                return;
            end
            sym  = want_symbol.pop_front();
            last = want_last.pop_front();
            if (got_symbol !== sym)
                report($sformatf("result %0d: out_symbol %0d, expected %0d",
                                 symbols_out, got_symbol, sym));
            if (got_last !== last)
                report($sformatf("result %0d: end_of_block %0b, expected %0b",
                                 symbols_out, got_last, last));
        endtask
    endclass

    deint_scoreboard sb;

    dvbt_bit_inner_deinterleaver_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_symbol    (in_symbol),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_symbol   (out_symbol),
        .end_of_block (end_of_block),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_symbol, end_of_block);
    end

    // Output side: random stalls, or a long hold-off once the main flow asks for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_trigger)
            begin
                hold_trigger = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < idle_pct);
        end
    end

    task automatic cfg_write(dbid_pkg::mode_t value);
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = MODE_ADDR;
        pwdata  = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.mode = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic cfg_check();
        @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b0;
        penable = 1'b0;
        paddr   = MODE_ADDR;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== 32'(sb.mode))
            sb.report($sformatf("mode register reads %0d, expected %0d", prdata, sb.mode));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_symbol(dbid_pkg::sym_t value);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        in_symbol = value;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(value);
    endtask

    // Stops offering requests and waits for every expected symbol, then waits out
    // the SETTLE period so that silent first-block requests have left the pipeline too.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.want_symbol.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    initial
    begin
        int count;
        sb        = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_symbol = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        cfg_check();
        cfg_write(dbid_pkg::MODE_64QAM);
        cfg_check();

        // Two whole blocks at six bits fill every plane of both banks, so any
        // later mode, or a mode change inside a block, reads only written bits.
        foreach (CORNER_SYMBOLS[i])
            send_symbol(CORNER_SYMBOLS[i]);
        for (int i = $size(CORNER_SYMBOLS); i < 2 * SPAN; i++)
            send_symbol(dbid_pkg::sym_t'($urandom));

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            idle_pct = (ph == 2) ? 0 : IDLE_PCT;
            if (ph == 4)
                hold_trigger = 1'b1;
            cfg_write(MODE_PLAN[ph]);
            cfg_check();
            count = 140 + $urandom_range(60);
            repeat (count)
                send_symbol(dbid_pkg::sym_t'($urandom));
        end
        drain();

        $display("tb: %0d symbols in, %0d symbols out, QPSK, 16QAM, 64QAM and the spare mode",
                 sb.symbols_in, sb.symbols_out);
        $display("tb: mode changes landed mid-block; one long output hold-off backed up the input");
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dbid_pkg.sv
rtl/dbid_plane_ram.sv
rtl/dvbt_bit_inner_deinterleaver_unit.sv
tb/dvbt_bit_inner_deinterleaver_unit_tb.sv
